>>> hw/rtl/tls_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tls_pkg - shared types and constants for the token scanner
// Character codes, token kinds, scan modes and the front-to-back queue entry.
// ============================================================================
package tls_pkg;

    localparam int POSITION_BITS_DEF     = 16;
    localparam int KEYWORD_COUNT_DEF     = 7;
    localparam int KEYWORD_MAX_BYTES_DEF = 8;

    localparam int KEYWORD_BITS   = 64;
    localparam int KIND_BITS      = 5;
    localparam int START_BITS     = 16;
    localparam int LEN_BITS       = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_EQ     = 3'd3,
        MODE_BANG   = 3'd4
    } scan_mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        TK_ILLEGAL   = 5'd0,
        TK_EOF       = 5'd1,
        TK_IDENT     = 5'd2,
        TK_INT       = 5'd3,
        TK_ASSIGN    = 5'd4,
        TK_EQ        = 5'd5,
        TK_NEQ       = 5'd6,
        TK_NOT       = 5'd7,
        TK_PLUS      = 5'd8,
        TK_MINUS     = 5'd9,
        TK_STAR      = 5'd10,
        TK_DIV       = 5'd11,
        TK_LESS      = 5'd12,
        TK_GREATER   = 5'd13,
        TK_COMMA     = 5'd14,
        TK_SEMICOLON = 5'd15,
        TK_LPAREN    = 5'd16,
        TK_RPAREN    = 5'd17,
        TK_LBRACE    = 5'd18,
        TK_RBRACE    = 5'd19,
        TK_KEYWORD0  = 5'd20,
        TK_KEYWORD1  = 5'd21,
        TK_KEYWORD2  = 5'd22,
        TK_KEYWORD3  = 5'd23,
        TK_KEYWORD4  = 5'd24,
        TK_KEYWORD5  = 5'd25,
        TK_KEYWORD6  = 5'd26
    } token_kind_t;

    // One accepted byte gives at most two tokens: a flushed pending token
    // (slot 0) and a token of the byte itself (slot 1).
    typedef struct packed {
        logic                    has0;
        token_kind_t             kind0;
        logic                    kw_check0;
        logic [START_BITS-1:0]   start0;
        logic [LEN_BITS-1:0]     len0;
        logic [KEYWORD_BITS-1:0] shift0;
        logic                    has1;
        token_kind_t             kind1;
        logic [START_BITS-1:0]   start1;
        logic                    len1;
    } scan_entry_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic token_kind_t single_kind(input logic [7:0] c);
        token_kind_t k;
        unique case (c)
            CH_PLUS:      k = TK_PLUS;
            CH_MINUS:     k = TK_MINUS;
            CH_STAR:      k = TK_STAR;
            CH_SLASH:     k = TK_DIV;
            CH_LESS:      k = TK_LESS;
            CH_GREATER:   k = TK_GREATER;
            CH_COMMA:     k = TK_COMMA;
            CH_SEMICOLON: k = TK_SEMICOLON;
            CH_LPAREN:    k = TK_LPAREN;
            CH_RPAREN:    k = TK_RPAREN;
            CH_LBRACE:    k = TK_LBRACE;
            CH_RBRACE:    k = TK_RBRACE;
            default:      k = TK_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

>>> hw/rtl/tls_front.sv
`timescale 1ns / 1ps
// ============================================================================
// tls_front - byte classifier and run tracker
// Takes one source byte per beat, tracks the pending token and pushes the
// tokens the byte completes into the queue.
// ============================================================================
module tls_front #(
    parameter int POSITION_BITS     = tls_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_BYTES = tls_pkg::KEYWORD_MAX_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           source_byte,
    input  logic                 queue_full,
    output logic                 push,
    output tls_pkg::scan_entry_t push_entry
);
    import tls_pkg::*;

    localparam int SHIFT_BITS = 8 * KEYWORD_MAX_BYTES;

    scan_mode_t               mode_reg, mode_next;
    logic [POSITION_BITS-1:0] begin_reg, begin_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [LEN_BITS-1:0]      run_len_reg, run_len_next;
    logic [SHIFT_BITS-1:0]    shift_reg, shift_next;
    logic [POSITION_BITS-1:0] pos_inc;
    logic                     fire;
    logic                     restart;
    scan_entry_t              entry;

    assign in_stall = queue_full;
    assign fire     = in_valid && !queue_full;
    assign pos_inc  = pos_reg + 1'b1;

    always_comb
    begin
        mode_next    = mode_reg;
        begin_next   = begin_reg;
        pos_next     = pos_inc;
        run_len_next = run_len_reg;
        shift_next   = shift_reg;
        restart      = 1'b1;

        entry           = '0;
        entry.kind0     = TK_ILLEGAL;
        entry.kind1     = TK_ILLEGAL;
        entry.start0    = START_BITS'(begin_reg);
        entry.len0      = run_len_reg;
        entry.shift0    = KEYWORD_BITS'(shift_reg);
        entry.kw_check0 = 1'b0;
        entry.start1    = START_BITS'(pos_reg);

        unique case (mode_reg)
            MODE_IDENT, MODE_NUMBER:
            begin
                if ((mode_reg == MODE_IDENT) ? is_alpha(source_byte)
                                             : is_digit(source_byte))
                begin
                    restart = 1'b0;
                    for (int j = 0; j < KEYWORD_MAX_BYTES; j++)
                    begin
                        if (run_len_reg == LEN_BITS'(j))
                            shift_next[8*j +: 8] = source_byte;
                    end
                    if (run_len_reg != '1)
                        run_len_next = run_len_reg + 1'b1;
                end
                else
                begin
                    entry.has0 = 1'b1;
                    if (mode_reg == MODE_IDENT)
                    begin
                        entry.kind0     = TK_IDENT;
                        entry.kw_check0 = (run_len_reg <= LEN_BITS'(KEYWORD_MAX_BYTES));
                    end
                    else
                        entry.kind0 = TK_INT;
                end
            end
            MODE_EQ, MODE_BANG:
            begin
                entry.has0 = 1'b1;
                if (source_byte == CH_EQUAL)
                begin
                    restart     = 1'b0;
                    mode_next   = MODE_IDLE;
                    entry.kind0 = (mode_reg == MODE_EQ) ? TK_EQ : TK_NEQ;
                    entry.len0  = LEN_BITS'(2);
                end
                else
                begin
                    entry.kind0 = (mode_reg == MODE_EQ) ? TK_ASSIGN : TK_NOT;
                    entry.len0  = LEN_BITS'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (restart)
        begin
            mode_next = MODE_IDLE;
            if (source_byte == CH_NUL)
            begin
                entry.has1  = 1'b1;
                entry.kind1 = TK_EOF;
                entry.len1  = 1'b0;
                pos_next    = '0;
            end
            else if (is_space(source_byte))
            begin
            end
            else if (is_alpha(source_byte) || is_digit(source_byte))
            begin
                mode_next    = is_alpha(source_byte) ? MODE_IDENT : MODE_NUMBER;
                begin_next   = pos_reg;
                run_len_next = LEN_BITS'(1);
                shift_next   = SHIFT_BITS'(source_byte);
            end
            else if (source_byte == CH_EQUAL || source_byte == CH_BANG)
            begin
                mode_next  = (source_byte == CH_EQUAL) ? MODE_EQ : MODE_BANG;
                begin_next = pos_reg;
            end
            else
            begin
                entry.has1  = 1'b1;
                entry.kind1 = single_kind(source_byte);
                entry.len1  = 1'b1;
            end
        end
    end

    assign push       = fire && (entry.has0 || entry.has1);
    assign push_entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            begin_reg   <= '0;
            pos_reg     <= '0;
            run_len_reg <= '0;
            shift_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            begin_reg   <= begin_next;
            pos_reg     <= pos_next;
            run_len_reg <= run_len_next;
            shift_reg   <= shift_next;
        end
    end

endmodule

>>> hw/rtl/tls_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// tls_queue - short FIFO between classifier and token emitter
// Holds per-byte token pairs so either side can stall on its own.
// ============================================================================
module tls_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tls_pkg::scan_entry_t push_entry,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output tls_pkg::scan_entry_t head
);
    import tls_pkg::*;

    scan_entry_t          mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

>>> hw/rtl/tls_back.sv
`timescale 1ns / 1ps
// ============================================================================
// tls_back - keyword lookup and token emitter
// Resolves identifiers against the keyword registers and sends the one or
// two tokens of each queue entry out through a registered output.
// ============================================================================
module tls_back #(
    parameter int KEYWORD_COUNT = tls_pkg::KEYWORD_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tls_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tls_pkg::KEYWORD_BITS-1:0]    cfg_wdata,
    input  logic                                head_valid,
    input  tls_pkg::scan_entry_t                head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tls_pkg::KIND_BITS-1:0]       token_kind,
    output logic [tls_pkg::START_BITS-1:0]      token_start,
    output logic [tls_pkg::LEN_BITS-1:0]        token_length,
    output logic                                last_of_run
);
    import tls_pkg::*;

    logic [KEYWORD_BITS-1:0]   kw_reg [KEYWORD_COUNT];
    logic                      kw_hit;
    logic [CFG_INDEX_BITS-1:0] kw_sel;
    token_kind_t               kind0;

    logic                  out_valid_reg, out_valid_next;
    token_kind_t           kind_reg, kind_next;
    logic [START_BITS-1:0] start_reg, start_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic                  last_reg, last_next;
    logic                  sub_reg, sub_next;
    logic                  load;
    logic                  emit_second;

    // descending scan so the lowest-numbered register wins
    always_comb
    begin
        kw_hit = 1'b0;
        kw_sel = '0;
        for (int i = KEYWORD_COUNT - 1; i >= 0; i--)
        begin
            if (kw_reg[i] != '0 && kw_reg[i] == head.shift0)
            begin
                kw_hit = 1'b1;
                kw_sel = CFG_INDEX_BITS'(i);
            end
        end
        kind0 = head.kind0;
        if (head.kw_check0 && kw_hit)
            kind0 = token_kind_t'(KIND_BITS'(TK_KEYWORD0) + KIND_BITS'(kw_sel));
    end

    assign load        = !out_valid_reg || !out_stall;
    assign emit_second = sub_reg || !head.has0;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        sub_next       = sub_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                if (!emit_second)
                begin
                    kind_next  = kind0;
                    start_next = head.start0;
                    len_next   = head.len0;
                    last_next  = !head.has1;
                    sub_next   = head.has1;
                    pop        = !head.has1;
                end
                else
                begin
                    kind_next  = head.kind1;
                    start_next = head.start1;
                    len_next   = LEN_BITS'(head.len1);
                    last_next  = 1'b1;
                    sub_next   = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEYWORD_COUNT; i++)
                kw_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < KEYWORD_COUNT; i++)
            begin
                if (cfg_index == CFG_INDEX_BITS'(i))
                    kw_reg[i] <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        start_reg <= start_next;
        len_reg   <= len_next;
        last_reg  <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = kind_reg;
    assign token_start  = start_reg;
    assign token_length = len_reg;
    assign last_of_run  = last_reg;

`ifndef ASSERT_OFF
    a_sub_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> head_valid && head.has0 && head.has1)
        else $error("second token pending without a pair at queue head");
    a_nonlast_then_sub: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> sub_reg)
        else $error("non-final beat without a pending second token");
    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == TK_EOF) |-> (len_reg == '0) && last_reg)
        else $error("eof token with nonzero length or not final");
`endif

endmodule

>>> hw/rtl/toy_language_token_scanner.sv
`timescale 1ns / 1ps
// ============================================================================
// toy_language_token_scanner - streaming token scanner, one byte per beat
// Classifier front end, a 4-entry token queue, and a keyword-resolving
// emitter with a registered output.
// ============================================================================
//  channel | signals                                        | beat
//  --------+------------------------------------------------+-------------------
//  in      | in_valid, in_stall, source_byte                | one source byte
//  out     | out_valid, out_stall, token_kind, token_start, | one token
//          | token_length, last_of_run                      |
//  cfg     | cfg_we, cfg_index, cfg_wdata                   | one keyword write
//
// Input takes one byte per cycle; in_stall rises only when the queue is full.
// Output gives one token per cycle while out_stall is low; a byte that both ends a
// pending token and forms its own gives two tokens in turn, so sustained rate is
// set by the output port and the tokens-per-byte mix. No clearing pass after
// reset; control and keyword state clear at once, token data is not reset.
// ============================================================================
module toy_language_token_scanner #(
    parameter int POSITION_BITS     = tls_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_COUNT     = tls_pkg::KEYWORD_COUNT_DEF,
    parameter int KEYWORD_MAX_BYTES = tls_pkg::KEYWORD_MAX_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         source_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tls_pkg::KIND_BITS-1:0]      token_kind,
    output logic [tls_pkg::START_BITS-1:0]     token_start,
    output logic [tls_pkg::LEN_BITS-1:0]       token_length,
    output logic                               last_of_run,
    input  logic                               cfg_we,
    input  logic [tls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tls_pkg::KEYWORD_BITS-1:0]   cfg_wdata
);
    import tls_pkg::*;

    logic        push, pop, full, head_valid;
    scan_entry_t push_entry, head;

    tls_front #(
        .POSITION_BITS     (POSITION_BITS),
        .KEYWORD_MAX_BYTES (KEYWORD_MAX_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .source_byte (source_byte),
        .queue_full  (full),
        .push        (push),
        .push_entry  (push_entry)
    );

    tls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    tls_back #(
        .KEYWORD_COUNT (KEYWORD_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

endmodule
